FILE: rtl/salru_pkg.sv
package salru_pkg;

  // request kinds
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_BAD    = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  // configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  // configuration reset values
  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        extra_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_we;
    logic accept;
    logic decide;
    logic scan_step;
    logic commit;
    logic use_saved;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic resolved;
    logic ways_one;
    logic scan_last;
  } dp_status_t;

endpackage

FILE: rtl/salru_ctrl.sv
module salru_ctrl
  import salru_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_WAIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.decide = 1'b1;
        if (status.resolved && out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else if (status.resolved || status.ways_one) begin
          state_next = ST_WAIT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd.use_saved = 1'b1;
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/salru_dp.sv
module salru_dp
  import salru_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int STAMP_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_item,
  output out_item_t             out_item,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int ROW_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W    = $clog2(MAX_WAYS + 1);

  typedef logic [MAX_WAYS-1:0][31:0]            tag_row_t;
  typedef logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_row_t;

  // configuration
  logic [2:0] set_bits;
  logic [3:0] ways_in_use;
  logic [4:0] block_bits;

  // request registers
  logic [1:0]             kind_q;
  logic [ROW_W-1:0]       set_q;
  logic [31:0]            tag_q;
  logic [STAMP_WIDTH-1:0] access_clock;
  logic [STAMP_WIDTH-1:0] clock_inc;

  // counters
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] eviction_count;

  // stores and read rows
  tag_row_t   tag_mem   [NUM_SETS];
  stamp_row_t stamp_mem [NUM_SETS];
  tag_row_t   tag_row;
  stamp_row_t stamp_row;
  tag_row_t   tag_row_w;
  stamp_row_t stamp_row_w;
  logic       mem_we;
  logic [ROW_W-1:0] wr_set;
  logic [ROW_W-1:0] clr_ptr;

  // decision and victim scan
  logic [1:0]             outcome_q;
  logic [WAY_W-1:0]       way_q;
  logic [WAY_W-1:0]       scan_ptr;
  logic [STAMP_WIDTH-1:0] min_q;

  // address split
  logic [3:0]       sb_eff;
  logic [4:0]       ways_sat;
  logic [CNT_W-1:0] ways_eff;
  logic [31:0]      shifted;
  logic [31:0]      set_mask;
  logic [31:0]      set_full;
  logic [ROW_W-1:0] set_in;
  logic [31:0]      tag_in;

  // way lookup
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] empty_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    empty_way;
  logic [1:0]          look_outcome;
  logic [WAY_W-1:0]    look_way;
  logic [1:0]          sel_outcome;
  logic [WAY_W-1:0]    sel_way;
  logic                extra;
  logic [1:0]          hit_inc;
  logic                miss_inc;
  logic                evict_inc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RST;
      ways_in_use <= WAYS_RST;
      block_bits  <= BLOCK_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits    <= cfg_data[2:0];
        CFG_WAYS:       ways_in_use <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // saturated set bits and way count
  always_comb begin
    if ({1'b0, set_bits} > 4'(MAX_SET_BITS)) begin
      sb_eff = 4'(MAX_SET_BITS);
    end else begin
      sb_eff = {1'b0, set_bits};
    end
    if (ways_in_use == 4'd0) begin
      ways_sat = 5'd1;
    end else if ({1'b0, ways_in_use} > 5'(MAX_WAYS)) begin
      ways_sat = 5'(MAX_WAYS);
    end else begin
      ways_sat = {1'b0, ways_in_use};
    end
    ways_eff = CNT_W'(ways_sat);
  end

  // set index and tag of the incoming address
  assign shifted  = in_item.address >> block_bits;
  assign set_mask = (32'd1 << sb_eff) - 32'd1;
  assign set_full = shifted & set_mask;
  assign set_in   = set_full[ROW_W-1:0];
  assign tag_in   = shifted >> sb_eff;

  // access clock skips zero on wrap
  assign clock_inc = access_clock + STAMP_WIDTH'(1);

  // request registers and access clock
  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
    end else if (cmd.accept) begin
      access_clock <= (clock_inc == '0) ? STAMP_WIDTH'(1) : clock_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= in_item.req_type;
      set_q  <= set_in;
      tag_q  <= tag_in;
    end
  end

  // hit and empty way search over the set
  always_comb begin
    hit_vec   = '0;
    empty_vec = '0;
    hit_way   = '0;
    empty_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (CNT_W'(w) < ways_eff) begin
        hit_vec[w]   = (stamp_row[w] != '0) && (tag_row[w] == tag_q);
        empty_vec[w] = (stamp_row[w] == '0);
      end
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (empty_vec[w]) begin
        empty_way = WAY_W'(w);
      end
    end
  end

  // outcome of the lookup
  always_comb begin
    if (kind_q == REQ_BAD) begin
      look_outcome = OUT_NONE;
      look_way     = '0;
    end else if (|hit_vec) begin
      look_outcome = OUT_HIT;
      look_way     = hit_way;
    end else if (|empty_vec) begin
      look_outcome = OUT_FILL;
      look_way     = empty_way;
    end else begin
      look_outcome = OUT_EVICT;
      look_way     = '0;
    end
  end

  assign sel_outcome = cmd.use_saved ? outcome_q : look_outcome;
  assign sel_way     = cmd.use_saved ? way_q : look_way;

  // saved decision and oldest stamp scan
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      outcome_q <= look_outcome;
      way_q     <= look_way;
      min_q     <= stamp_row[0];
      scan_ptr  <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (stamp_row[scan_ptr] < min_q) begin
        way_q <= scan_ptr;
        min_q <= stamp_row[scan_ptr];
      end
      scan_ptr <= scan_ptr + WAY_W'(1);
    end
  end

  // counter updates
  assign extra     = (kind_q == REQ_MODIFY) && (sel_outcome != OUT_NONE);
  assign hit_inc   = {1'b0, extra} + {1'b0, sel_outcome == OUT_HIT};
  assign miss_inc  = (sel_outcome == OUT_FILL) || (sel_outcome == OUT_EVICT);
  assign evict_inc = (sel_outcome == OUT_EVICT);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else if (cmd.commit) begin
      hit_count      <= hit_count + 32'(hit_inc);
      miss_count     <= miss_count + 32'(miss_inc);
      eviction_count <= eviction_count + 32'(evict_inc);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.outcome        <= sel_outcome;
      out_item.extra_hit      <= extra;
      out_item.hit_total      <= hit_count + 32'(hit_inc);
      out_item.miss_total     <= miss_count + 32'(miss_inc);
      out_item.eviction_total <= eviction_count + 32'(evict_inc);
    end
  end

  // clearing pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear_we) begin
      clr_ptr <= clr_ptr + ROW_W'(1);
    end
  end

  // line write data
  always_comb begin
    tag_row_w   = tag_row;
    stamp_row_w = stamp_row;
    if (cmd.clear_we) begin
      tag_row_w   = '0;
      stamp_row_w = '0;
    end else begin
      tag_row_w[sel_way]   = tag_q;
      stamp_row_w[sel_way] = access_clock;
    end
  end

  assign mem_we = cmd.clear_we || (cmd.commit && (sel_outcome != OUT_NONE));
  assign wr_set = cmd.clear_we ? clr_ptr : set_q;

  // tag store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[wr_set] <= tag_row_w;
    end
    if (cmd.accept) begin
      tag_row <= tag_mem[set_in];
    end
  end

  // stamp store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[wr_set] <= stamp_row_w;
    end
    if (cmd.accept) begin
      stamp_row <= stamp_mem[set_in];
    end
  end

  // status
  assign status.clear_last = (clr_ptr == ROW_W'(NUM_SETS - 1));
  assign status.resolved   = (look_outcome != OUT_EVICT);
  assign status.ways_one   = (ways_eff == CNT_W'(1));
  assign status.scan_last  = (CNT_W'(scan_ptr) == ways_eff - CNT_W'(1));

endmodule

FILE: rtl/set_assoc_cache_lru_sim.sv
// a hit, a fill or an unknown kind commits from the lookup state unless output stalls
// an eviction adds an oldest-stamp scan over the ways in use, one way per cycle
// one access at a time; the set row is read once and written at most once
// reset: counters, access clock and configuration take their reset values, then
// a clearing pass over all 2**MAX_SET_BITS sets zeroes the tag and stamp stores
module set_assoc_cache_lru_sim
  import salru_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int STAMP_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  salru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // stores, lookup and counters
  salru_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: sim/salru_checker.sv
module salru_checker
  import salru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    n_hit,
  output int                    n_fill,
  output int                    n_evict
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_MAX = 6;
  localparam int WAY_MAX = 8;
  localparam int LINES   = (1 << SET_MAX) * WAY_MAX;

  // shadow cache contents and counters
  logic [31:0] tags   [LINES];
  logic [31:0] stamps [LINES];
  logic [31:0] access_now;
  logic [31:0] hits;
  logic [31:0] misses;
  logic [31:0] evicts;

  // shadow configuration
  logic [2:0] set_bits;
  logic [3:0] ways;
  logic [4:0] blk_bits;

  out_item_t expected_q[$];
  out_item_t want;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_v);
  endtask

  // one cache access: lookup, fill or lru eviction, and the running totals
  function automatic out_item_t cache_access(in_item_t it);
    int          sb;
    int          nw;
    int          base;
    int          victim;
    logic [31:0] idx;
    logic [31:0] tag;
    logic        ext;
    bit          done;
    out_item_t   r;
    sb = (set_bits > SET_MAX) ? SET_MAX : int'(set_bits);
    nw = (ways == 0) ? 1 : ((ways > WAY_MAX) ? WAY_MAX : int'(ways));
    access_now = access_now + 32'd1;
    if (access_now == 32'd0)
      access_now = 32'd1;
    ext = 1'b0;
    r.outcome = OUT_NONE;
    if (it.req_type != REQ_BAD) begin
      // a modify counts its second access as a hit up front
      if (it.req_type == REQ_MODIFY) begin
        hits = hits + 32'd1;
        ext = 1'b1;
      end
      idx  = (it.address >> blk_bits) & ((32'd1 << sb) - 32'd1);
      tag  = (it.address >> blk_bits) >> sb;
      base = int'(idx) * WAY_MAX;
      done = 1'b0;
      for (int w = 0; w < nw; w++) begin
        if (!done && stamps[base+w] != 0 && tags[base+w] == tag) begin
          hits = hits + 32'd1;
          stamps[base+w] = access_now;
          r.outcome = OUT_HIT;
          done = 1'b1;
        end
      end
      for (int w = 0; w < nw; w++) begin
        if (!done && stamps[base+w] == 0) begin
          misses = misses + 32'd1;
          stamps[base+w] = access_now;
          tags[base+w] = tag;
          r.outcome = OUT_FILL;
          done = 1'b1;
        end
      end
      // oldest stamp goes, first one on a tie
      if (!done) begin
        victim = 0;
        for (int w = 1; w < nw; w++)
          if (stamps[base+w] < stamps[base+victim])
            victim = w;
        misses = misses + 32'd1;
        evicts = evicts + 32'd1;
        stamps[base+victim] = access_now;
        tags[base+victim] = tag;
        r.outcome = OUT_EVICT;
      end
    end
    r.extra_hit      = ext;
    r.hit_total      = hits;
    r.miss_total     = misses;
    r.eviction_total = evicts;
    return r;
  endfunction

  // watch config writes and both channels
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        tags[i]   = '0;
        stamps[i] = '0;
      end
      access_now = '0;
      hits       = '0;
      misses     = '0;
      evicts     = '0;
      set_bits   = SET_BITS_RST;
      ways       = WAYS_RST;
      blk_bits   = BLOCK_BITS_RST;
      errors     = 0;
      n_hit      = 0;
      n_fill     = 0;
      n_evict    = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits = cfg_data[2:0];
          CFG_WAYS:       ways     = cfg_data[3:0];
          CFG_BLOCK_BITS: blk_bits = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(cache_access(in_item));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("result transfer with nothing expected, hit_total", out_item.hit_total, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_item.outcome !== want.outcome)
            report("outcome", 32'(out_item.outcome), 32'(want.outcome));
          if (out_item.extra_hit !== want.extra_hit)
            report("extra_hit", 32'(out_item.extra_hit), 32'(want.extra_hit));
          if (out_item.hit_total !== want.hit_total)
            report("hit_total", out_item.hit_total, want.hit_total);
          if (out_item.miss_total !== want.miss_total)
            report("miss_total", out_item.miss_total, want.miss_total);
          if (out_item.eviction_total !== want.eviction_total)
            report("eviction_total", out_item.eviction_total, want.eviction_total);
          case (want.outcome)
            OUT_HIT:   n_hit++;
            OUT_FILL:  n_fill++;
            OUT_EVICT: n_evict++;
            default: ;
          endcase
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: sim/tb.sv
module tb
  import salru_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int n_hit;
  int n_fill;
  int n_evict;

  // stimulus bookkeeping
  int          n_items;
  int          n_cfg;
  bit          calm;
  int          eff_sb;
  int          eff_ways;
  int          cur_bb;
  logic [31:0] addr_pool [32];
  int          n_pool;

  set_assoc_cache_lru_sim DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  salru_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .n_hit     (n_hit),
    .n_fill    (n_fill),
    .n_evict   (n_evict)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side back-pressure: mostly ready, short stalls, a few long ones
  initial begin
    int hold;
    int r;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
          out_ready <= 1'b1;
          hold = calm ? 0 : $urandom_range(0, 4);
        end else if (r < 94) begin
          out_ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // write all three registers and remember the effective geometry
  task automatic set_cfg(input int sb, input int nw, input int bb);
    write_cfg(CFG_SET_BITS, CFG_DATA_W'(sb));
    write_cfg(CFG_WAYS, CFG_DATA_W'(nw));
    write_cfg(CFG_BLOCK_BITS, CFG_DATA_W'(bb));
    eff_sb   = (sb > 6) ? 6 : sb;
    eff_ways = (nw == 0) ? 1 : ((nw > 8) ? 8 : nw);
    cur_bb   = bb;
    n_cfg++;
  endtask

  // one input transfer, with an optional idle gap in front
  task automatic access(input logic [1:0] kind, input logic [31:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= '{req_type: kind, address: addr};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  // drop valid and wait until every result is back and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // addresses that share two sets, so hits and evictions are frequent
  task automatic build_pool();
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] t;
    logic [31:0] s;
    logic [63:0] a;
    n_pool = $urandom_range(2, 2 * eff_ways + 3);
    s0 = $urandom;
    s1 = $urandom;
    for (int i = 0; i < n_pool; i++) begin
      t = $urandom;
      if ($urandom_range(0, 1) == 1)
        t = t & 32'h0000_000f;
      s = ($urandom_range(0, 1) == 1) ? s0 : s1;
      s = s & ((32'd1 << eff_sb) - 32'd1);
      a = ({32'd0, t} << (cur_bb + eff_sb)) | ({32'd0, s} << cur_bb);
      addr_pool[i] = a[31:0];
    end
  endtask

  task automatic random_phase(input int count);
    int          r;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [63:0] offs;
    calm = ($urandom_range(0, 3) == 0);
    build_pool();
    for (int i = 0; i < count; i++) begin
      // switch idling on or off halfway through
      if (i == count / 2)
        calm = ~calm;
      r = $urandom_range(0, 99);
      if (r < 45)
        kind = REQ_LOAD;
      else if (r < 72)
        kind = REQ_STORE;
      else if (r < 95)
        kind = REQ_MODIFY;
      else
        kind = REQ_BAD;
      if ($urandom_range(0, 9) < 8) begin
        offs = {32'd0, $urandom} & ((64'd1 << cur_bb) - 64'd1);
        addr = addr_pool[$urandom_range(0, n_pool - 1)] | offs[31:0];
      end else begin
        addr = $urandom;
      end
      access(kind, addr);
    end
    settle();
  endtask

  // stimulus and verdict
  initial begin
    int cfg_list [6][3];
    cfg_list = '{'{7, 15, 31}, '{6, 8, 26}, '{0, 0, 0}, '{3, 4, 5}, '{1, 2, 9}, '{5, 3, 2}};
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SET_BITS;
    cfg_data  = '0;
    n_items   = 0;
    n_cfg     = 0;
    calm      = 1'b0;
    eff_sb    = int'(SET_BITS_RST);
    eff_ways  = int'(WAYS_RST);
    cur_bb    = int'(BLOCK_BITS_RST);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry, one way: fill, hit within a block, conflict evictions,
    // modify on hit and on miss, unknown kinds, all-ones address
    access(REQ_LOAD,   32'h0000_0000);
    access(REQ_LOAD,   32'h0000_000f);
    access(REQ_STORE,  32'h0000_0100);
    access(REQ_MODIFY, 32'h0000_0000);
    access(REQ_MODIFY, 32'h0000_0008);
    access(REQ_BAD,    32'hffff_ffff);
    access(REQ_LOAD,   32'hffff_ffff);
    access(REQ_STORE,  32'hffff_fff0);
    access(REQ_BAD,    32'h0000_0000);
    settle();

    // one fully associative set of eight ways: fill it, refresh one way,
    // then push new tags so the oldest stamps go first
    set_cfg(0, 8, 0);
    for (int i = 0; i < 8; i++)
      access(REQ_LOAD, 32'(i));
    access(REQ_LOAD,   32'd3);
    access(REQ_LOAD,   32'd8);
    access(REQ_MODIFY, 32'd0);
    access(REQ_STORE,  32'd9);
    settle();

    // random traffic over fixed extremes and then random geometries
    for (int p = 0; p < 10; p++) begin
      if (p < 6)
        set_cfg(cfg_list[p][0], cfg_list[p][1], cfg_list[p][2]);
      else
        set_cfg($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31));
      random_phase(80);
    end

    $display("summary: %0d accesses across %0d register settings", n_items, n_cfg);
    $display("summary: results checked: %0d hits, %0d fills, %0d evictions",
             n_hit, n_fill, n_evict);
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
